>>> hdl/mpws_pkg.sv
// ----------------------------------------------------------------------------
// mpws_pkg
// shared codes, defaults, channel control struct and target clamp
// ----------------------------------------------------------------------------
`default_nettype none

package mpws_pkg;

  localparam int CHANNELS_DEF  = 8;
  localparam int DUTY_BITS_DEF = 16;

  localparam logic [15:0] PERIOD_RESET = 16'd1000;
  localparam logic [15:0] MIN_PERIOD   = 16'd2;

  // item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_DUTY = 2'd2;

  // per-channel update controls for one item
  typedef struct packed {
    logic advance;  // item is applied this cycle
    logic wrap;     // tick that starts a new period
    logic reg_wr;   // register item for this channel
    logic duty_wr;  // duty target item for this channel
    logic invert;   // phase invert bit of a register item
  } ctl_t;

  // targets at or above the period become period minus 2
  function automatic logic [31:0] clamp32(input logic [31:0] v, input logic [15:0] p);
    logic [31:0] r;
    if (v >= {16'd0, p}) begin
      r = {16'd0, p} - 32'd2;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/multichannel_pwm_with_slew.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_with_slew
// pwm channels on one shared period counter with per-channel duty slewing
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   tdata: channel, duty, step, invert; tuser: kind
//  m_       out  m_tvalid/m_tready   tdata: channel levels; tuser: period start
//  cfg_     in   cfg_valid/cfg_ready period length
//
//  one item per clock sustained while the output is not stalled; each item
//  is captured in the input register and its result is then registered in
//  the output register. the count, slew adders and level compares of all
//  channels work in parallel between the input and output registers.
//  rst clears the counter and all channel state, period goes to 1000.
//  a stalled output holds its result while one more item waits in the
//  input register; the input stalls only when both are full.
//
`default_nettype none

module multichannel_pwm_with_slew #(
  parameter int CHANNELS  = mpws_pkg::CHANNELS_DEF,
  parameter int DUTY_BITS = mpws_pkg::DUTY_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // input items
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // channel_index[2:0], duty_value[18:3],
                                 // step_size[34:19], phase_invert[35], zero[39:36]
  input  wire  [1:0]  s_tuser,   // kind[1:0]
  // result items
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // channel_levels[7:0]
  output logic [0:0]  m_tuser,   // period_start[0]
  // period length register
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data
);

  // config register, always writable
  logic [15:0] period_length;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_length <= mpws_pkg::PERIOD_RESET;
    end else if (cfg_valid) begin
      period_length <= cfg_data;
    end
  end

  // input register
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [2:0]  s1_ch;
  logic [15:0] s1_duty;
  logic [15:0] s1_step;
  logic        s1_ph;
  logic        advance;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_kind <= s_tuser;
      s1_ch   <= s_tdata[2:0];
      s1_duty <= s_tdata[18:3];
      s1_step <= s_tdata[34:19];
      s1_ph   <= s_tdata[35];
    end
  end

  // period counter
  logic [15:0] period;
  logic [15:0] tick_count;
  logic [15:0] tick_next;
  logic [16:0] tick_inc;
  logic        is_tick;
  logic        wrap;

  // a period below the minimum runs as the minimum
  assign period   = (period_length < mpws_pkg::MIN_PERIOD) ? mpws_pkg::MIN_PERIOD
                                                           : period_length;
  assign is_tick  = (s1_kind == mpws_pkg::KIND_TICK);
  assign tick_inc = 17'(tick_count) + 17'd1;
  // a counter left beyond a shrunken period wraps on the next tick
  assign wrap     = is_tick && ((tick_count >= period) || (tick_inc >= 17'(period)));

  always_comb begin
    if (!is_tick) begin
      tick_next = tick_count;
    end else if (wrap) begin
      tick_next = '0;
    end else begin
      tick_next = tick_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (advance) begin
      tick_count <= tick_next;
    end
  end

  // shared clamp of a new duty target, and the slew step at channel width
  logic [DUTY_BITS-1:0] duty_tgt;
  logic [DUTY_BITS-1:0] step;

  assign duty_tgt = DUTY_BITS'(mpws_pkg::clamp32(32'(s1_duty), period));
  assign step     = DUTY_BITS'(32'(s1_step));

  // channel array; indexes beyond the array never match and are ignored
  logic [CHANNELS-1:0] level;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    mpws_pkg::ctl_t ctl;
    logic           hit;

    assign hit         = ({4'd0, s1_ch} == 7'(c));
    assign ctl.advance = advance;
    assign ctl.wrap    = wrap;
    assign ctl.reg_wr  = hit && (s1_kind == mpws_pkg::KIND_REG);
    assign ctl.duty_wr = hit && (s1_kind == mpws_pkg::KIND_DUTY);
    assign ctl.invert  = s1_ph;

    mpws_channel #(
      .DUTY_BITS (DUTY_BITS)
    ) u_ch (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .period    (period),
      .tick_next (tick_next),
      .duty_tgt  (duty_tgt),
      .step      (step),
      .level     (level[c])
    );
  end

  // only the first eight channels are reported
  logic [7:0] levels8;

  for (genvar b = 0; b < 8; b++) begin : g_lv
    if (b < CHANNELS) begin : g_on
      assign levels8[b] = level[b];
    end else begin : g_off
      assign levels8[b] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= levels8;
      m_tuser[0] <= wrap;
    end
  end

  // a wrapping tick leaves the counter at zero
  a_wrap_zero : assert property (@(posedge clk) disable iff (rst)
    advance && wrap |=> tick_count == '0)
    else $error("counter not zero after period start");

  // only ticks report a period start
  a_pstart_tick : assert property (@(posedge clk) disable iff (rst)
    advance && !is_tick |=> !m_tuser[0])
    else $error("period start on a non-tick item");

  // non-tick items leave the counter alone
  a_count_hold : assert property (@(posedge clk) disable iff (rst)
    advance && !is_tick |=> tick_count == $past(tick_count))
    else $error("counter moved on a non-tick item");

  // input stalls only with the input register full and the output blocked
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid && m_tvalid && !m_tready)
    else $error("input stalled without cause");

endmodule

`default_nettype wire

>>> hdl/mpws_channel.sv
// ----------------------------------------------------------------------------
// mpws_channel
// one pwm channel: target, duty, slew step, slew update and level compare
// ----------------------------------------------------------------------------
`default_nettype none

module mpws_channel #(
  parameter int DUTY_BITS = mpws_pkg::DUTY_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  mpws_pkg::ctl_t       ctl,
  input  wire [15:0]           period,     // effective period, at least 2
  input  wire [15:0]           tick_next,  // count after this item
  input  wire [DUTY_BITS-1:0]  duty_tgt,   // already clamped
  input  wire [DUTY_BITS-1:0]  step,
  output logic                 level       // level after this item
);

  logic [DUTY_BITS-1:0] target;
  logic [DUTY_BITS-1:0] current;
  logic [DUTY_BITS-1:0] slew;
  logic                 inverted;
  logic                 enabled;

  logic [DUTY_BITS-1:0] current_next;
  logic [DUTY_BITS-1:0] diff;
  logic [DUTY_BITS-1:0] move;
  logic [DUTY_BITS-1:0] target_reclamp;

  assign target_reclamp = DUTY_BITS'(mpws_pkg::clamp32(32'(target), period));

  // slew an enabled channel toward target on period start; zero slew jumps to it
  always_comb begin
    current_next = current;
    diff         = (current < target) ? (target - current) : (current - target);
    move         = (diff < slew) ? diff : slew;
    if (ctl.wrap && enabled && (current != target)) begin
      if (slew == '0) begin
        current_next = target;
      end else if (current < target) begin
        current_next = current + move;
      end else begin
        current_next = current - move;
      end
    end
  end

  // level against the post-item state
  always_comb begin
    logic en_n;
    logic inv_n;
    en_n  = enabled | ctl.reg_wr;
    inv_n = ctl.reg_wr ? ctl.invert : inverted;
    if (!en_n) begin
      level = 1'b0;
    end else if (inv_n) begin
      level = (33'(tick_next) + 33'(current_next)) >= 33'(period);
    end else begin
      level = 32'(tick_next) < 32'(current_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target   <= '0;
      current  <= '0;
      slew     <= '0;
      inverted <= 1'b0;
      enabled  <= 1'b0;
    end else if (ctl.advance) begin
      current <= current_next;
      if (ctl.reg_wr) begin
        inverted <= ctl.invert;
        slew     <= step;
        enabled  <= 1'b1;
        target   <= target_reclamp;
      end else if (ctl.duty_wr) begin
        target <= duty_tgt;
      end
    end
  end

endmodule

`default_nettype wire
